### rtl/i2a_pkg.sv
`timescale 1ns / 1ps
// i2a_pkg: shared types, constants and the digit table for the integer to ascii block
// no dependencies

package i2a_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CHAR_BITS  = 7;
  localparam int CMD_BITS   = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_BIN = 2'd0,
    CMD_OCT = 2'd1,
    CMD_DEC = 2'd2,
    CMD_HEX = 2'd3
  } radix_t;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic out_load;
    logic sel_minus;
    logic last;
  } ctl_cmd_t;

  typedef struct packed {
    logic neg;
    logic digit_zero;
  } dp_status_t;

  // decimal digits needed for an unsigned word of wb bits
  function automatic int dec_digits(input int wb);
    return ((wb * 1233) >> 12) + 1;
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_BITS-1:0] c;
    case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'hA: c = 7'h41;
      4'hB: c = 7'h42;
      4'hC: c = 7'h43;
      4'hD: c = 7'h44;
      4'hE: c = 7'h45;
      default: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage

### rtl/i2a_if.sv
`timescale 1ns / 1ps
// i2a_in_if and i2a_out_if: valid/ready channels for words in and characters out
// depends on i2a_pkg

interface i2a_in_if;
  import i2a_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          cmd;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface i2a_out_if;
  import i2a_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] ascii_char;
  logic                 last_char;
  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

### rtl/i2a_dp.sv
`timescale 1ns / 1ps
// i2a_dp: word shift register, bcd converter and output character register
// depends on i2a_pkg

module i2a_dp #(
  parameter int WORD_BITS = 32
) (
  input  logic                                     clk,
  input  i2a_pkg::ctl_cmd_t                        ctl,
  input  logic [i2a_pkg::CMD_BITS-1:0]             cmd,
  input  logic signed [i2a_pkg::VALUE_BITS-1:0]    value,
  output i2a_pkg::dp_status_t                      status,
  output logic [i2a_pkg::CHAR_BITS-1:0]            ascii_char,
  output logic                                     last_char
);
  import i2a_pkg::*;

  localparam int XW     = WORD_BITS + 3;
  localparam int NDIG   = dec_digits(WORD_BITS);
  localparam int BW     = 4 * NDIG;
  localparam int N_OCT  = (WORD_BITS + 2) / 3;
  localparam int N_HEX  = (WORD_BITS + 3) / 4;
  localparam int SH_OCT = XW - 3 * N_OCT;
  localparam int SH_HEX = XW - 4 * N_HEX;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mag;
  logic                 word_neg;
  logic [XW-1:0]        sh;
  logic [XW-1:0]        sh_next;
  logic [BW-1:0]        bcd;
  logic [BW-1:0]        bcd_next;
  logic [BW-1:0]        bcd_adj;
  logic                 neg;
  radix_t               mode;
  logic [3:0]           digit;

  if (WORD_BITS <= VALUE_BITS) begin : g_trunc
    assign word = value[WORD_BITS-1:0];
  end else begin : g_ext
    assign word = {{(WORD_BITS-VALUE_BITS){value[VALUE_BITS-1]}}, value};
  end

  assign word_neg = word[WORD_BITS-1];
  assign mag      = word_neg ? (~word + WORD_BITS'(1)) : word;

  // add 3 to each bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    case (mode)
      CMD_BIN: digit = {3'b000, sh[XW-1]};
      CMD_OCT: digit = {1'b0, sh[XW-1 -: 3]};
      CMD_DEC: digit = bcd[BW-1 -: 4];
      default: digit = sh[XW-1 -: 4];
    endcase
  end

  always_comb begin
    sh_next  = sh;
    bcd_next = bcd;
    if (ctl.load) begin
      bcd_next = '0;
      case (radix_t'(cmd))
        CMD_BIN: sh_next = {word, 3'b000};
        CMD_OCT: sh_next = {3'b000, word} << SH_OCT;
        CMD_DEC: sh_next = {mag, 3'b000};
        default: sh_next = {3'b000, word} << SH_HEX;
      endcase
    end else if (ctl.dabble) begin
      bcd_next = {bcd_adj[BW-2:0], sh[XW-1]};
      sh_next  = sh << 1;
    end else if (ctl.shift) begin
      case (mode)
        CMD_BIN: sh_next = sh << 1;
        CMD_OCT: sh_next = sh << 3;
        CMD_DEC: bcd_next = bcd << 4;
        default: sh_next = sh << 4;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sh  <= sh_next;
    bcd <= bcd_next;
    if (ctl.load) begin
      mode <= radix_t'(cmd);
      neg  <= word_neg;
    end
    if (ctl.out_load) begin
      ascii_char <= ctl.sel_minus ? CHAR_MINUS : digit_char(digit);
      last_char  <= ctl.last;
    end
  end

  assign status.neg        = neg;
  assign status.digit_zero = (digit == 4'd0);

endmodule

### rtl/i2a_ctrl.sv
`timescale 1ns / 1ps
// i2a_ctrl: sequencer for load, bcd conversion, sign and digit emission
// depends on i2a_pkg

module i2a_ctrl #(
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [i2a_pkg::CMD_BITS-1:0]  in_cmd,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  input  i2a_pkg::dp_status_t           status,
  output i2a_pkg::ctl_cmd_t             ctl
);
  import i2a_pkg::*;

  localparam int CW    = $clog2(WORD_BITS);
  localparam int NDIG  = dec_digits(WORD_BITS);
  localparam int N_OCT = (WORD_BITS + 2) / 3;
  localparam int N_HEX = (WORD_BITS + 3) / 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DABBLE,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  radix_t        mode;
  radix_t        mode_next;
  logic          started;
  logic          started_next;
  logic          out_valid_next;
  logic          can_emit;

  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    cnt_next       = cnt;
    mode_next      = mode;
    started_next   = started;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load     = 1'b1;
          mode_next    = radix_t'(in_cmd);
          started_next = 1'b0;
          case (radix_t'(in_cmd))
            CMD_BIN: begin
              state_next = S_EMIT;
              cnt_next   = CW'(WORD_BITS - 1);
            end
            CMD_OCT: begin
              state_next = S_EMIT;
              cnt_next   = CW'(N_OCT - 1);
            end
            CMD_DEC: begin
              state_next = S_DABBLE;
              cnt_next   = CW'(WORD_BITS - 1);
            end
            default: begin
              state_next = S_EMIT;
              cnt_next   = CW'(N_HEX - 1);
            end
          endcase
        end
      end
      S_DABBLE: begin
        ctl.dabble = 1'b1;
        cnt_next   = cnt - CW'(1);
        if (cnt == '0) begin
          cnt_next   = CW'(NDIG - 1);
          state_next = status.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (can_emit) begin
          ctl.out_load  = 1'b1;
          ctl.sel_minus = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        // leading zero of a decimal: drop it without a transaction
        if (mode == CMD_DEC && !started && status.digit_zero && cnt != '0) begin
          ctl.shift = 1'b1;
          cnt_next  = cnt - CW'(1);
        end else if (can_emit) begin
          ctl.out_load = 1'b1;
          ctl.shift    = 1'b1;
          ctl.last     = (cnt == '0);
          started_next = 1'b1;
          cnt_next     = cnt - CW'(1);
          if (cnt == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = ctl.out_load || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      mode      <= CMD_BIN;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      mode      <= mode_next;
      started   <= started_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
// integer_to_ascii_radix_top: word to ascii text in binary, octal, signed decimal or hex
// depends on i2a_pkg, i2a_if, i2a_ctrl, i2a_dp
//
//   channel  dir  payload                 one transaction
//   item     in   cmd[1:0], value[31:0]   one word to convert
//   text     out  ascii_char[6:0], last   one character, last on the final one
//
// binary, octal and hex: a load, then every digit is emitted, leading zeros included
// decimal: a load, a shift-add-3 bcd conversion of the magnitude, then a minus sign
//   if negative, then the digits, with leading zeros dropped without a transaction
// one character leaves per cycle from the output register; a stall on text holds it
// a new word is taken once the last character of the previous one is registered
// rst is synchronous and returns the sequencer to idle with no character pending

module integer_to_ascii_radix_top #(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  i2a_in_if.sink    item,
  i2a_out_if.source text
);
  import i2a_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  i2a_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_cmd    (item.cmd),
    .in_ready  (item.ready),
    .out_ready (text.ready),
    .out_valid (text.valid),
    .status    (status),
    .ctl       (ctl)
  );

  i2a_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .ctl        (ctl),
    .cmd        (item.cmd),
    .value      (item.value),
    .status     (status),
    .ascii_char (text.ascii_char),
    .last_char  (text.last_char)
  );

endmodule

### rtl/i2a_checker.sv
`timescale 1ns / 1ps
// i2a_checker: port-level assertions for integer_to_ascii_radix_top
// depends on i2a_pkg; bound to the top level below

module i2a_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [i2a_pkg::CHAR_BITS-1:0]   ascii_char,
  input logic                            last_char
);
  import i2a_pkg::*;

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_char))
    else $error("stalled character changed");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while converting");

  // only digits, uppercase hex letters and minus
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char >= 7'h30 && ascii_char <= 7'h39) ||
                  (ascii_char >= 7'h41 && ascii_char <= 7'h46) ||
                  (ascii_char == CHAR_MINUS))
    else $error("illegal character");

  // text never ends on a sign
  a_last_not_minus: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_char |-> ascii_char != CHAR_MINUS)
    else $error("text ends on minus");

endmodule

bind integer_to_ascii_radix_top i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .out_valid  (text.valid),
  .out_ready  (text.ready),
  .ascii_char (text.ascii_char),
  .last_char  (text.last_char)
);
